// ===== rtl/bracket_balance_checker_core_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros used by the checker file of the bracket balance block.
// ---------------------------------------------------------------------------
`ifndef BRACKET_BALANCE_CHECKER_CORE_MACROS_SVH
`define BRACKET_BALANCE_CHECKER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BBC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bracket balance checker: same-cycle property failed");

// The consequent must hold in the cycle after the antecedent.
`define BBC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bracket balance checker: next-cycle property failed");

`endif

// ===== rtl/bbc_pkg.sv =====
// ---------------------------------------------------------------------------
// bbc_pkg
// Types and constants shared by the bracket balance checker modules.
// ---------------------------------------------------------------------------
`default_nettype none

package bbc_pkg;

   // Deepest nesting the opener stack holds.
   localparam int MAX_DEPTH = 64;
   // Width of a count from 0 to MAX_DEPTH.
   localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1);
   // Width of an index into the stack memory.
   localparam int ADDR_W    = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_ROPEN  = 8'h28;
   localparam logic [7:0] CH_RCLOSE = 8'h29;
   localparam logic [7:0] CH_SOPEN  = 8'h5B;
   localparam logic [7:0] CH_SCLOSE = 8'h5D;

   // Opener kinds as stored on the stack.
   localparam logic KIND_ROUND  = 1'b0;
   localparam logic KIND_SQUARE = 1'b1;

   typedef struct packed {
      logic [7:0] character;
      logic       last;
   } bbc_req_type;

   typedef struct packed {
      logic valid_res;
      logic overflow;
   } bbc_rsp_type;

   // Command from the byte parser to the stack.
   typedef struct packed {
      logic push;
      logic pop;
      logic kind;
      logic clear;
   } bbc_stack_cmd_type;

   // Stack status seen by the byte parser.
   typedef struct packed {
      logic empty;
      logic one;
      logic full;
      logic tos;
   } bbc_stack_stat_type;

endpackage

`default_nettype wire

// ===== rtl/bbc_stack_ram.sv =====
// ---------------------------------------------------------------------------
// bbc_stack_ram
// One-bit-wide synchronous memory holding the stacked opener kinds.
// ---------------------------------------------------------------------------
`default_nettype none

module bbc_stack_ram (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [bbc_pkg::ADDR_W-1:0] wr_addr,
   input  wire logic                       wr_data,
   input  wire logic [bbc_pkg::ADDR_W-1:0] rd_addr,
   output logic                            rd_data
);

   logic mem [bbc_pkg::MAX_DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read-before-write: a same-address read returns the old contents.
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ===== rtl/bbc_stack.sv =====
// ---------------------------------------------------------------------------
// bbc_stack
// Opener stack: top entry in a register, the rest in memory, with the
// entry below the top prefetched every cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module bbc_stack (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire bbc_pkg::bbc_stack_cmd_type  cmd,
   output bbc_pkg::bbc_stack_stat_type      stat
);

   logic [bbc_pkg::DEPTH_W-1:0] depth_ff, depth_in;
   logic                        tos_ff, tos_in;
   logic                        fwd_ff, fwd_in;
   logic                        fwd_data_ff;

   logic                        wr_en;
   logic [bbc_pkg::DEPTH_W-1:0] wr_index;
   logic [bbc_pkg::DEPTH_W-1:0] rd_index;
   logic                        rd_data;
   logic                        below;

   // A push writes the old top exactly where the next prefetch reads, so
   // the written bit is forwarded for one cycle.
   assign below = fwd_ff ? fwd_data_ff : rd_data;

   always_comb begin
      depth_in = depth_ff;
      tos_in   = tos_ff;
      if (cmd.clear) begin
         depth_in = '0;
      end else if (cmd.push) begin
         depth_in = depth_ff + bbc_pkg::DEPTH_W'(1);
         tos_in   = cmd.kind;
      end else if (cmd.pop) begin
         depth_in = depth_ff - bbc_pkg::DEPTH_W'(1);
         tos_in   = below;
      end
   end

   assign wr_en    = cmd.push && !cmd.clear && (depth_ff != '0);
   assign wr_index = depth_ff - bbc_pkg::DEPTH_W'(1);
   assign rd_index = depth_in - bbc_pkg::DEPTH_W'(2);
   assign fwd_in   = wr_en;

   bbc_stack_ram u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_index[bbc_pkg::ADDR_W-1:0]),
      .wr_data (tos_ff),
      .rd_addr (rd_index[bbc_pkg::ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
         fwd_ff   <= 1'b0;
      end else begin
         depth_ff <= depth_in;
         fwd_ff   <= fwd_in;
      end
   end

   always_ff @(posedge clock) begin
      tos_ff      <= tos_in;
      fwd_data_ff <= tos_ff;
   end

   assign stat.empty = (depth_ff == '0);
   assign stat.one   = (depth_ff == bbc_pkg::DEPTH_W'(1));
   assign stat.full  = (depth_ff == bbc_pkg::DEPTH_W'(bbc_pkg::MAX_DEPTH));
   assign stat.tos   = tos_ff;

endmodule

`default_nettype wire

// ===== rtl/bracket_balance_checker_core.sv =====
// ---------------------------------------------------------------------------
// bracket_balance_checker_core
// Checks byte strings for balanced round and square brackets, with double
// quotes masking brackets, and reports one verdict per string.
// ---------------------------------------------------------------------------
// Usage: the sender presents one byte of a string per beat on req_data, with
// req_data.last set on the final byte. Strings hold at least one byte. The
// block takes one byte every cycle while req_stall is low; each byte does
// at most one stack push or pop and one compare, as the top opener sits in
// a register and the entry below it is prefetched from the stack memory.
// Bytes that are not the last produce no beat on the response channel.
// The last byte produces one response beat in the cycle after it is accepted:
// rsp_data.valid_res is set when the brackets matched, the stack ended empty,
// no quote was left open and the nesting never went beyond MAX_DEPTH;
// rsp_data.overflow is set when a push was attempted at full depth.
// After the last byte all string state clears, so the next byte starts a
// new string. Reset clears the state at once; there is no clearing pass,
// since stack entries are only ever read after being written.
// The response sits in an output register. While it waits and rsp_stall is
// high, req_stall is raised; otherwise bytes keep flowing.
// ---------------------------------------------------------------------------
`default_nettype none

module bracket_balance_checker_core (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire bbc_pkg::bbc_req_type req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output bbc_pkg::bbc_rsp_type      rsp_data
);

   // String state held in flops; the opener kinds live in the stack.
   logic in_quotes_ff, in_quotes_in;
   logic mismatch_ff,  mismatch_in;
   logic overflow_ff,  overflow_in;

   logic                 rsp_valid_ff;
   bbc_pkg::bbc_rsp_type rsp_data_ff;

   bbc_pkg::bbc_stack_cmd_type  stack_cmd;
   bbc_pkg::bbc_stack_stat_type stack_stat;

   logic accept;
   logic last_beat;
   logic active;
   logic outside;
   logic is_open;
   logic is_close;
   logic want_kind;
   logic push_req;
   logic pop_req;
   logic mismatch_set;
   logic overflow_set;
   logic empty_after;
   logic verdict_ok;

   // The input only waits when a finished response is held up downstream.
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign last_beat = accept && req_data.last;

   // Once a string has failed, its bytes are ignored, quotes included.
   assign active = accept && !mismatch_ff && !overflow_ff;

   always_comb begin
      in_quotes_in = in_quotes_ff;
      if (active && (req_data.character == bbc_pkg::CH_QUOTE)) begin
         in_quotes_in = !in_quotes_ff;
      end
   end

   // Brackets count only outside quotes, judged after the toggle above.
   assign outside  = active && !in_quotes_in;
   assign is_open  = (req_data.character == bbc_pkg::CH_ROPEN) ||
                     (req_data.character == bbc_pkg::CH_SOPEN);
   assign is_close = (req_data.character == bbc_pkg::CH_RCLOSE) ||
                     (req_data.character == bbc_pkg::CH_SCLOSE);
   assign push_req = outside && is_open;
   assign pop_req  = outside && is_close;

   assign want_kind = (req_data.character == bbc_pkg::CH_SCLOSE) ?
                      bbc_pkg::KIND_SQUARE : bbc_pkg::KIND_ROUND;

   // A push at full depth stores nothing and fails the string. A closer on
   // an empty stack, or on an opener of the other kind, fails it as well.
   assign overflow_set = push_req && stack_stat.full;
   assign mismatch_set = pop_req &&
                         (stack_stat.empty || (stack_stat.tos != want_kind));

   assign stack_cmd.push  = push_req && !stack_stat.full;
   assign stack_cmd.pop   = pop_req && !stack_stat.empty;
   assign stack_cmd.kind  = (req_data.character == bbc_pkg::CH_SOPEN) ?
                            bbc_pkg::KIND_SQUARE : bbc_pkg::KIND_ROUND;
   assign stack_cmd.clear = last_beat;

   bbc_stack u_stack (
      .clock (clock),
      .reset (reset),
      .cmd   (stack_cmd),
      .stat  (stack_stat)
   );

   assign mismatch_in = mismatch_ff || mismatch_set;
   assign overflow_in = overflow_ff || overflow_set;

   // Stack emptiness as it stands after this byte.
   always_comb begin
      if (stack_cmd.push) begin
         empty_after = 1'b0;
      end else if (stack_cmd.pop) begin
         empty_after = stack_stat.one;
      end else begin
         empty_after = stack_stat.empty;
      end
   end

   assign verdict_ok = !mismatch_in && !overflow_in && empty_after && !in_quotes_in;

   always_ff @(posedge clock) begin
      if (reset || last_beat) begin
         in_quotes_ff <= 1'b0;
         mismatch_ff  <= 1'b0;
         overflow_ff  <= 1'b0;
      end else begin
         in_quotes_ff <= in_quotes_in;
         mismatch_ff  <= mismatch_in;
         overflow_ff  <= overflow_in;
      end
   end

   // Output register: loaded on a last byte, emptied when the beat is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (last_beat) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (last_beat) begin
         rsp_data_ff.valid_res <= verdict_ok;
         rsp_data_ff.overflow  <= overflow_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== rtl/bbc_checker.sv =====
// ---------------------------------------------------------------------------
// bbc_checker
// Port-level properties of the bracket balance checker, bound to its top.
// ---------------------------------------------------------------------------
`default_nettype none

`include "bracket_balance_checker_core_macros.svh"

module bbc_checker (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_valid,
   input wire logic                 req_stall,
   input wire bbc_pkg::bbc_req_type req_data,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_stall,
   input wire bbc_pkg::bbc_rsp_type rsp_data
);

   logic req_take;

   assign req_take = req_valid && !req_stall;

   // A response beat held by the receiver stays, with the same payload.
   `BBC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `BBC_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_data))

   // Every accepted last byte yields a response in the following cycle.
   `BBC_ASSERT_NEXT(a_last_gives_rsp, clock, reset, req_take && req_data.last, rsp_valid)

   // Bytes inside a string never produce a response of their own.
   `BBC_ASSERT_NEXT(a_mid_no_rsp, clock, reset, req_take && !req_data.last, !rsp_valid)

   // An overflowed string is never reported as balanced.
   `BBC_ASSERT_SAME(a_ovf_not_ok, clock, reset, rsp_valid && rsp_data.overflow, !rsp_data.valid_res)

endmodule

bind bracket_balance_checker_core bbc_checker u_bbc_checker (.*);

`default_nettype wire
